FILE: rtl/core/clsb_pkg.sv
package clsb_pkg;

   // pin masks on the LED port
   localparam logic [7:0] PinLed1 = 8'h01;
   localparam logic [7:0] PinLed2 = 8'h02;
   localparam logic [7:0] PinLed3 = 8'h04;
   localparam logic [7:0] PinLed4 = 8'h08;
   localparam logic [7:0] PinLed5 = 8'h10;
   localparam logic [7:0] PinLed6 = 8'h40;

   localparam logic [7:0] ScanDirInit = 8'b0101_1111;

   localparam logic [15:0] PwmTopReset       = 16'd199;
   localparam logic [15:0] RampIntervalReset = 16'd200;

   localparam int CsrIndexWidth = 8;
   localparam logic [CsrIndexWidth-1:0] CsrPwmTop       = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CsrRampInterval = 8'd1;

   typedef struct packed {
      logic       charge_full;
      logic       forced_full_long;
      logic       charger_present;
      logic       charge_mode;
      logic [9:0] led_pattern;
   } req_fields_type;

   typedef struct packed {
      logic       breathing_on;
      logic [7:0] tristate_out;
      logic [7:0] port_out;
   } rsp_fields_type;

endpackage

FILE: rtl/core/charlieplex_led_scan_breathing_top.sv
// Charlieplexed LED scan with a breathing charge indicator. Each request transfer is one
// tick: it carries the LED pattern and the charging flags, and yields exactly one response
// transfer with the port latch, the direction latch and the breathing flag after that tick.
// The response sits in a single output register and is valid in the cycle after its
// request transfer; a new request is taken every cycle as long as the response side
// takes the previous result in the same cycle. The two CSRs (index 0 pwm_top, index 1
// ramp_interval) may be written at any time the block is idle; csr_ready is always high
// and unknown indexes are ignored.
module charlieplex_led_scan_breathing_top (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [9:0] led_pattern, [10] charge_mode, [11] charger_present,
   // [12] forced_full_long, [13] charge_full, [15:14] zero
   input  logic [15:0]                       req_tdata,

   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] port_out, [15:8] tristate_out, [16] breathing_on, [23:17] zero
   output logic [23:0]                       rsp_tdata,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [clsb_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [15:0]                       csr_data
);

   clsb_pkg::req_fields_type req;
   clsb_pkg::rsp_fields_type rsp_ff, rsp_in;

   logic [15:0] pwm_top_ff, pwm_top_in;
   logic [15:0] ramp_interval_ff, ramp_interval_in;

   logic [7:0]  port_ff, port_in;
   logic [7:0]  tris_ff, tris_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] counter_ff, counter_in;
   logic [15:0] duty_ff, duty_in;
   logic [15:0] timer_ff, timer_in;
   logic        falling_ff, falling_in;
   logic        breath_ff, breath_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        req_xfer;
   logic [9:0]  pat;
   logic [15:0] cnt_inc;
   logic [15:0] tmr_inc;

   assign req = clsb_pkg::req_fields_type'(req_tdata[13:0]);

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff};

   always_comb begin
      pwm_top_in       = pwm_top_ff;
      ramp_interval_in = ramp_interval_ff;
      if (csr_valid) begin
         unique case (csr_index)
            clsb_pkg::CsrPwmTop:       pwm_top_in       = csr_data;
            clsb_pkg::CsrRampInterval: ramp_interval_in = csr_data;
            default: ;
         endcase
      end
   end

   // one tick: charge stage, then scan stage when breathing is off
   always_comb begin
      port_in    = port_ff;
      tris_in    = tris_ff;
      phase_in   = phase_ff;
      counter_in = counter_ff;
      duty_in    = duty_ff;
      timer_in   = timer_ff;
      falling_in = falling_ff;
      breath_in  = breath_ff;
      pat        = req.led_pattern;
      cnt_inc    = counter_ff + 16'd1;
      tmr_inc    = timer_ff + 16'd1;

      if (req.charge_mode) begin
         if (req.charger_present) begin
            port_in = port_in & ~(clsb_pkg::PinLed1 | clsb_pkg::PinLed2 | clsb_pkg::PinLed6);
            tris_in = tris_in & ~(clsb_pkg::PinLed1 | clsb_pkg::PinLed2 | clsb_pkg::PinLed6);
            if (req.forced_full_long) begin
               breath_in = 1'b0;
               pat[9:8]  = 2'b00;
            end else if (req.charge_full) begin
               breath_in = 1'b0;
               pat[9:8]  = 2'b01;
            end else begin
               breath_in = 1'b1;
               if (duty_ff >= cnt_inc) begin
                  port_in = (port_in | clsb_pkg::PinLed3 | clsb_pkg::PinLed4)
                            & ~clsb_pkg::PinLed5;
                  tris_in = tris_in
                            & ~(clsb_pkg::PinLed3 | clsb_pkg::PinLed4 | clsb_pkg::PinLed5);
               end else begin
                  port_in = port_in & ~(clsb_pkg::PinLed3 | clsb_pkg::PinLed5);
                  tris_in = tris_in & ~(clsb_pkg::PinLed3 | clsb_pkg::PinLed5);
               end
               counter_in = (cnt_inc >= pwm_top_ff) ? 16'd0 : cnt_inc;
               if (tmr_inc >= ramp_interval_ff) begin
                  timer_in = 16'd0;
                  if (!falling_ff) begin
                     if (duty_ff >= pwm_top_ff) falling_in = 1'b1;
                     duty_in = duty_ff + 16'd1;
                  end else begin
                     duty_in = duty_ff - 16'd1;
                     if (duty_in == 16'd0) falling_in = 1'b0;
                  end
               end else begin
                  timer_in = tmr_inc;
               end
            end
         end
      end else begin
         breath_in  = 1'b0;
         counter_in = 16'd0;
         timer_in   = 16'd0;
      end

      if (!breath_in) begin
         tris_in = clsb_pkg::ScanDirInit;
         case (phase_ff)
            2'd0: begin
               if (pat[0]) begin
                  port_in = port_in & ~clsb_pkg::PinLed2;
                  tris_in = tris_in & ~clsb_pkg::PinLed2;
               end
               if (pat[1]) begin
                  port_in = port_in & ~clsb_pkg::PinLed3;
                  tris_in = tris_in & ~clsb_pkg::PinLed3;
               end
               if (pat[2]) begin
                  port_in = port_in & ~clsb_pkg::PinLed4;
                  tris_in = tris_in & ~clsb_pkg::PinLed4;
               end
               if (pat[3]) begin
                  port_in = port_in & ~clsb_pkg::PinLed5;
                  tris_in = tris_in & ~clsb_pkg::PinLed5;
               end
               if (pat[4]) begin
                  port_in = port_in & ~clsb_pkg::PinLed6;
                  tris_in = tris_in & ~clsb_pkg::PinLed6;
               end
               port_in = port_in | clsb_pkg::PinLed1;
               tris_in = tris_in & ~clsb_pkg::PinLed1;
            end
            2'd1: begin
               if (pat[5]) begin
                  port_in = port_in & ~clsb_pkg::PinLed4;
                  tris_in = tris_in & ~clsb_pkg::PinLed4;
               end
               if (pat[6]) begin
                  port_in = port_in & ~clsb_pkg::PinLed6;
                  tris_in = tris_in & ~clsb_pkg::PinLed6;
               end
               if (pat[7]) begin
                  port_in = port_in & ~clsb_pkg::PinLed5;
                  tris_in = tris_in & ~clsb_pkg::PinLed5;
               end
               port_in = port_in | clsb_pkg::PinLed2;
               tris_in = tris_in & ~clsb_pkg::PinLed2;
            end
            2'd2: begin
               if (pat[8]) begin
                  port_in = port_in & ~clsb_pkg::PinLed4;
                  tris_in = tris_in & ~clsb_pkg::PinLed4;
               end
               port_in = port_in | clsb_pkg::PinLed3;
               tris_in = tris_in & ~clsb_pkg::PinLed3;
            end
            default: begin
               if (pat[9]) begin
                  port_in = port_in & ~clsb_pkg::PinLed5;
                  tris_in = tris_in & ~clsb_pkg::PinLed5;
               end
               port_in = port_in | clsb_pkg::PinLed3;
               tris_in = tris_in & ~clsb_pkg::PinLed3;
            end
         endcase
         phase_in = phase_ff + 2'd1;
      end

      rsp_in.port_out     = port_in;
      rsp_in.tristate_out = tris_in;
      rsp_in.breathing_on = breath_in;
   end

   // hold the result until the response transfer, take a new one on each request transfer
   assign rsp_valid_in = req_xfer ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_top_ff       <= clsb_pkg::PwmTopReset;
         ramp_interval_ff <= clsb_pkg::RampIntervalReset;
         port_ff          <= 8'h00;
         tris_ff          <= 8'hFF;
         phase_ff         <= 2'd0;
         counter_ff       <= 16'd0;
         duty_ff          <= 16'd0;
         timer_ff         <= 16'd0;
         falling_ff       <= 1'b0;
         breath_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pwm_top_ff       <= pwm_top_in;
         ramp_interval_ff <= ramp_interval_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (req_xfer) begin
            port_ff    <= port_in;
            tris_ff    <= tris_in;
            phase_ff   <= phase_in;
            counter_ff <= counter_in;
            duty_ff    <= duty_in;
            timer_ff   <= timer_in;
            falling_ff <= falling_in;
            breath_ff  <= breath_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int ReqBits = $bits(clsb_pkg::req_fields_type);
   localparam int RspBits = $bits(clsb_pkg::rsp_fields_type);
   localparam int HoldCycles = 80;

   // indexes that no register answers to
   localparam logic [clsb_pkg::CsrIndexWidth-1:0] CsrUnmapped = 8'd2;
   localparam logic [clsb_pkg::CsrIndexWidth-1:0] CsrIndexTop = 8'hFF;

   typedef enum int {PaceOpen, PaceMostly, PaceThird, PaceCoin} pace_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;

   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [clsb_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   charlieplex_led_scan_breathing_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the LED driver state
   logic [15:0] cfg_top      = clsb_pkg::PwmTopReset;
   logic [15:0] cfg_interval = clsb_pkg::RampIntervalReset;
   logic [7:0]  pin_port     = 8'h00;
   logic [7:0]  pin_dir      = 8'hFF;
   logic [1:0]  scan_ph      = 2'd0;
   logic [15:0] pwm_count    = '0;
   logic [15:0] duty         = '0;
   logic [15:0] step_timer   = '0;
   logic        duty_falling = 1'b0;
   logic        breathing    = 1'b0;

   clsb_pkg::rsp_fields_type pins_due[$];

   int n_sent = 0;
   int n_checked = 0;
   int n_breathing = 0;
   int n_settings = 0;
   int mismatches = 0;
   int burst_left = 0;

   logic hold_flip = 1'b0;
   logic hold_seen = 1'b0;
   int hold_left = 0;
   int pace_left = 0;
   int pace_tick = 0;
   pace_mode_type pace_mode = PaceOpen;

   function automatic void pin_drive(input logic [7:0] pin, input logic high);
      if (high)
         pin_port = pin_port | pin;
      else
         pin_port = pin_port & ~pin;
      pin_dir = pin_dir & ~pin;
   endfunction

   function automatic void breathe_step();
      pwm_count = pwm_count + 16'd1;
      if (duty >= pwm_count) begin
         pin_drive(clsb_pkg::PinLed3, 1'b1);
         pin_drive(clsb_pkg::PinLed5, 1'b0);
         pin_drive(clsb_pkg::PinLed4, 1'b1);
      end else begin
         pin_drive(clsb_pkg::PinLed3, 1'b0);
         pin_drive(clsb_pkg::PinLed5, 1'b0);
      end
      if (pwm_count >= cfg_top)
         pwm_count = '0;
      step_timer = step_timer + 16'd1;
      if (step_timer >= cfg_interval) begin
         step_timer = '0;
         if (!duty_falling) begin
            if (duty >= cfg_top)
               duty_falling = 1'b1;
            duty = duty + 16'd1;
         end else begin
            duty = duty - 16'd1;
            if (duty == 16'd0)
               duty_falling = 1'b0;
         end
      end
   endfunction

   function automatic void scan_step(input logic [9:0] pat);
      pin_dir = clsb_pkg::ScanDirInit;
      case (scan_ph)
         2'd0: begin
            if (pat[0]) pin_drive(clsb_pkg::PinLed2, 1'b0);
            if (pat[1]) pin_drive(clsb_pkg::PinLed3, 1'b0);
            if (pat[2]) pin_drive(clsb_pkg::PinLed4, 1'b0);
            if (pat[3]) pin_drive(clsb_pkg::PinLed5, 1'b0);
            if (pat[4]) pin_drive(clsb_pkg::PinLed6, 1'b0);
            pin_drive(clsb_pkg::PinLed1, 1'b1);
         end
         2'd1: begin
            if (pat[5]) pin_drive(clsb_pkg::PinLed4, 1'b0);
            if (pat[6]) pin_drive(clsb_pkg::PinLed6, 1'b0);
            if (pat[7]) pin_drive(clsb_pkg::PinLed5, 1'b0);
            pin_drive(clsb_pkg::PinLed2, 1'b1);
         end
         2'd2: begin
            if (pat[8]) pin_drive(clsb_pkg::PinLed4, 1'b0);
            pin_drive(clsb_pkg::PinLed3, 1'b1);
         end
         default: begin
            if (pat[9]) pin_drive(clsb_pkg::PinLed5, 1'b0);
            pin_drive(clsb_pkg::PinLed3, 1'b1);
         end
      endcase
      scan_ph = scan_ph + 2'd1;
   endfunction

   function automatic clsb_pkg::rsp_fields_type next_pins(input clsb_pkg::req_fields_type f);
      logic [9:0] pat;
      clsb_pkg::rsp_fields_type r;
      pat = f.led_pattern;
      if (f.charge_mode) begin
         if (f.charger_present) begin
            pin_drive(clsb_pkg::PinLed1, 1'b0);
            pin_drive(clsb_pkg::PinLed2, 1'b0);
            pin_drive(clsb_pkg::PinLed6, 1'b0);
            if (f.forced_full_long) begin
               breathing = 1'b0;
               pat[9:8] = 2'b00;
            end else if (f.charge_full) begin
               breathing = 1'b0;
               pat[9:8] = 2'b01;
            end else begin
               breathing = 1'b1;
               breathe_step();
            end
         end
      end else begin
         breathing = 1'b0;
         pwm_count = '0;
         step_timer = '0;
      end
      if (!breathing)
         scan_step(pat);
      r.port_out = pin_port;
      r.tristate_out = pin_dir;
      r.breathing_on = breathing;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // watch every channel: predict on request, compare on response, track registers
   always @(posedge clock) begin
      clsb_pkg::rsp_fields_type got;
      clsb_pkg::rsp_fields_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               clsb_pkg::CsrPwmTop:       cfg_top = csr_data;
               clsb_pkg::CsrRampInterval: cfg_interval = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pins_due.push_back(next_pins(clsb_pkg::req_fields_type'(req_tdata[ReqBits-1:0])));
         if (rsp_tvalid && rsp_tready) begin
            n_checked++;
            got = clsb_pkg::rsp_fields_type'(rsp_tdata[RspBits-1:0]);
            if (pins_due.size() == 0) begin
               $error("response transfer with nothing expected: %0h", rsp_tdata);
               mismatches++;
            end else begin
               want = pins_due.pop_front();
               check_field("port_out", 16'(want.port_out), 16'(got.port_out));
               check_field("tristate_out", 16'(want.tristate_out), 16'(got.tristate_out));
               check_field("breathing_on", 16'(want.breathing_on), 16'(got.breathing_on));
               if (got.breathing_on)
                  n_breathing++;
            end
         end
      end
   end

   // response side: shifting stall patterns, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_flip != hold_seen) begin
         hold_seen = hold_flip;
         hold_left = HoldCycles;
      end
      if (pace_left == 0) begin
         pace_mode = pace_mode_type'($urandom_range(0, 3));
         pace_left = $urandom_range(16, 96);
      end
      pace_left--;
      pace_tick++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (pace_mode)
            PaceOpen:   rsp_tready <= 1'b1;
            PaceMostly: rsp_tready <= ($urandom_range(0, 3) != 0);
            PaceThird:  rsp_tready <= (pace_tick % 3 == 0);
            default:    rsp_tready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   task automatic send_tick(input logic [9:0] pat, input logic mode, input logic present,
                            input logic forced, input logic full);
      clsb_pkg::req_fields_type f;
      int gap;
      f.led_pattern = pat;
      f.charge_mode = mode;
      f.charger_present = present;
      f.forced_full_long = forced;
      f.charge_full = full;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {{(16 - ReqBits){1'b0}}, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_sent++;
   endtask

   task automatic send_breath();
      send_tick(10'($urandom), 1'b1, 1'b1, 1'b0, 1'b0);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (n_checked < n_sent) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes need a single assignment per step
   task automatic csr_put(input logic [clsb_pkg::CsrIndexWidth-1:0] idx,
                          input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] top, input logic [15:0] interval);
      wait_idle();
      csr_put(clsb_pkg::CsrPwmTop, top);
      csr_put(clsb_pkg::CsrRampInterval, interval);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic test_scan_and_charge_paths();
      // one pattern per scan phase, then each charge branch
      send_tick(10'h000, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(10'h3FF, 1'b0, 1'b1, 1'b1, 1'b1);
      send_tick(10'h155, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(10'h2AA, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(10'h01F, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(10'h0E0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(10'h100, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(10'h200, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(10'h3FF, 1'b1, 1'b0, 1'b0, 1'b0);
      send_tick(10'h3FF, 1'b1, 1'b1, 1'b1, 1'b0);
      send_tick(10'h000, 1'b1, 1'b1, 1'b0, 1'b1);
      send_tick(10'h3FF, 1'b1, 1'b1, 1'b1, 1'b1);
      send_tick(10'h000, 1'b1, 1'b1, 1'b0, 1'b1);
      repeat (3) send_breath();
      // charger pulled while breathing: scan stays suspended
      send_tick(10'h3FF, 1'b1, 1'b0, 1'b0, 1'b0);
      send_tick(10'h3FF, 1'b1, 1'b0, 1'b1, 1'b1);
      send_breath();
      send_tick(10'h3FF, 1'b0, 1'b1, 1'b0, 1'b0);
      send_tick(10'h0FF, 1'b0, 1'b0, 1'b0, 1'b0);
      wait_idle();
   endtask

   task automatic test_register_edges();
      set_config(16'd0, 16'd0);
      repeat (8) send_breath();
      set_config(16'd1, 16'd1);
      repeat (12) send_breath();
      set_config(16'hFFFF, 16'hFFFF);
      repeat (6) send_breath();
      set_config(16'hFFFF, 16'd1);
      repeat (10) send_breath();
      // writes to unmapped indexes must not disturb the ramp
      wait_idle();
      csr_put(CsrUnmapped, 16'($urandom));
      csr_put(CsrIndexTop, 16'($urandom));
      csr_valid <= 1'b0;
      repeat (6) send_breath();
      // short ramp: duty climbs past the top and comes back to zero
      set_config(16'd4, 16'd1);
      repeat (40) send_breath();
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int kind;
      int run;
      int cnt;
      logic [15:0] top;
      logic [15:0] interval;
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 0) begin
            top = 16'd1;
            interval = 16'd1;
         end else begin
            top = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 16'hFFFF))
                                               : 16'($urandom_range(1, 12));
            interval = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 16'hFFFF))
                                                    : 16'($urandom_range(1, 3));
         end
         set_config(top, interval);
         cnt = 0;
         while (cnt < 50) begin
            kind = $urandom_range(0, 9);
            run = (kind < 6) ? $urandom_range(4, 20) : $urandom_range(1, 4);
            repeat (run) begin
               case (kind)
                  0, 1, 2, 3, 4, 5: send_breath();
                  6: send_tick(10'($urandom), 1'b1, 1'b0, 1'($urandom), 1'($urandom));
                  7: send_tick(10'($urandom), 1'b1, 1'b1, 1'($urandom), 1'b1);
                  default: send_tick(10'($urandom), 1'($urandom), 1'($urandom),
                                     1'($urandom), 1'($urandom));
               endcase
               cnt++;
            end
         end
      end
      wait_idle();
   endtask

   task automatic test_output_stall();
      hold_flip <= ~hold_flip;
      repeat (30) begin
         if ($urandom_range(0, 1))
            send_breath();
         else
            send_tick(10'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                      1'($urandom));
      end
      wait_idle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_scan_and_charge_paths();
      test_register_edges();
      test_random_traffic();
      test_output_stall();
      set_config(clsb_pkg::PwmTopReset, clsb_pkg::RampIntervalReset);
      repeat (10) send_breath();
      wait_idle();
      repeat (4) @(posedge clock);
      $display("tb_top: %0d ticks checked, %0d of them breathing, over %0d register settings",
               n_checked, n_breathing, n_settings);
      $display("tb_top: covered scan phases, charge branches, ramp turnaround and a stall");
      if (mismatches == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_top: timeout, %0d sent, %0d checked", n_sent, n_checked);
      $display("tb_top: errors");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/clsb_pkg.sv
rtl/core/charlieplex_led_scan_breathing_top.sv
tb/tb_top.sv
